/* rtl/gmp_pkg.sv */
// shared widths, defaults and types for the grid max-path unit
`timescale 1ns / 1ps
package gmp_pkg;

	localparam int GAIN_W          = 16;
	localparam int COST_W          = 16;
	localparam int TOTAL_W         = 31;
	localparam int CFG_W           = 7;
	localparam int MAX_SIDE_DEF    = 64;
	localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

	// per-column or left-neighbor record: reachable flag and best total
	typedef struct packed {
		logic               reach;
		logic [TOTAL_W-1:0] total;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// where the cell sits in the grid
	typedef struct packed {
		logic first_row;
		logic first_col;
	} cell_pos_t;

endpackage

/* rtl/grid_max_path_with_edge_costs_unit.sv */
// top level of the grid max-path unit with edge costs
//
// channel  dir  handshake                 contents
// s_*      in   s_tvalid / s_tready       one grid cell per transaction, raster order
// m_*      out  m_tvalid / m_tready       final total and failure flag per grid
// cfg_*    in   cfg_wen                   grid_size register, no read-back
//
// one cell per cycle while the output is not stalled; a grid's last cell passes the input
// register (with the row-store read) and then the compute stage into the output register.
// the upper total comes from a row-store ram read at accept time; the left total
// is fed back from the previous cell's compute cycle.
// reset clears position, pipeline and output valids; grid_size returns to 64.
// a stalled output only holds the compute stage when it carries a grid's last cell.
`timescale 1ns / 1ps
module grid_max_path_with_edge_costs_unit #(
	parameter int MAX_SIDE = gmp_pkg::MAX_SIDE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_wen,
	input  logic [gmp_pkg::CFG_W-1:0] cfg_wdata,   // grid_size
	// cell stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [47:0]               s_tdata,     // cell_gain, cost_from_left, cost_from_above
	input  logic                      s_tuser,     // cell_blocked
	// result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,     // final_total, zero pad
	output logic                      m_tuser      // path_failed
);
	import gmp_pkg::*;

	localparam int IDX_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CNT_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

	logic [CFG_W-1:0] grid_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] side;
	logic [CNT_W-1:0] grid_ext;
	logic [CNT_W-1:0] cur_col;
	logic [CNT_W-1:0] cur_row;
	logic [CNT_W-1:0] col_nxt;
	logic [CNT_W-1:0] row_nxt;
	logic             last_col;
	logic             last_row;
	logic             in_acc;

	logic               valid_s1;
	logic [GAIN_W-1:0]  gain_s1;
	logic               blocked_s1;
	logic [COST_W-1:0]  cost_l_s1;
	logic [COST_W-1:0]  cost_u_s1;
	logic [IDX_W-1:0]   col_s1;
	cell_pos_t          pos_s1;
	logic               last_s1;
	logic               adv_s1;
	logic               fire_s1;

	node_t              left_q;
	node_t              up_node;
	node_t              cell_node;
	logic [NODE_W-1:0]  ram_rdata;

	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_failed_q;

	// effective side: zero acts as one, clipped to MAX_SIDE
	assign grid_ext = CNT_W'(grid_q);
	always_comb begin
		if (grid_q == '0) begin
			side = CNT_W'(1);
		end else if (grid_ext > CNT_W'(MAX_SIDE)) begin
			side = CNT_W'(MAX_SIDE);
		end else begin
			side = grid_ext;
		end
	end

	// position of the incoming cell and the step to the next one
	always_comb begin
		if (col_q >= side || row_q >= side) begin
			cur_col = '0;
			cur_row = '0;
		end else begin
			cur_col = col_q;
			cur_row = row_q;
		end
		col_nxt  = cur_col + CNT_W'(1);
		row_nxt  = cur_row + CNT_W'(1);
		last_col = !(col_nxt < side);
		last_row = !(row_nxt < side);
	end

	assign in_acc   = s_tvalid && s_tready;
	assign adv_s1   = !(last_s1 && out_valid_q && !m_tready);
	assign fire_s1  = valid_s1 && adv_s1;
	assign s_tready = !valid_s1 || adv_s1;

	// configuration register and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GRID_SIZE_RESET;
			col_q  <= '0;
			row_q  <= '0;
		end else if (cfg_wen) begin
			grid_q <= cfg_wdata;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_nxt;
			end else begin
				col_q <= col_nxt;
				row_q <= cur_row;
			end
		end
	end

	// input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register: payload and position
	always_ff @(posedge clk) begin
		if (in_acc) begin
			gain_s1           <= s_tdata[15:0];
			cost_l_s1         <= s_tdata[31:16];
			cost_u_s1         <= s_tdata[47:32];
			blocked_s1        <= s_tuser;
			col_s1            <= cur_col[IDX_W-1:0];
			pos_s1.first_row  <= (cur_row == '0);
			pos_s1.first_col  <= (cur_col == '0);
			last_s1           <= last_col && last_row;
		end
	end

	// row store: read the column at accept, write back in the compute cycle
	gmp_ram #(
		.WIDTH (NODE_W),
		.DEPTH (MAX_SIDE)
	) u_row_store (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (col_s1),
		.wdata (cell_node),
		.re    (in_acc),
		.raddr (cur_col[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign up_node = node_t'(ram_rdata);

	gmp_cell u_cell (
		.gain    (gain_s1),
		.blocked (blocked_s1),
		.cost_l  (cost_l_s1),
		.cost_u  (cost_u_s1),
		.pos     (pos_s1),
		.left    (left_q),
		.up      (up_node),
		.node    (cell_node)
	);

	// left neighbor record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (fire_s1) begin
			left_q <= cell_node;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_total_q  <= cell_node.total;
			out_failed_q <= !cell_node.reach || (cell_node.total == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_total_q};
	assign m_tuser  = out_failed_q;

	// a grid result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// a held compute stage keeps its cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(col_s1) && $stable(last_s1)))
		else $error("stalled cell lost");

	// position stays inside the grid
	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < side) && (row_q < side))
		else $error("position outside grid");

	// the last cell of a grid sends the position back to the start
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col && last_row && !cfg_wen) |=> (col_q == '0 && row_q == '0))
		else $error("position not wrapped after grid");

endmodule

/* rtl/gmp_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module gmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/gmp_cell.sv */
// one grid cell update: best neighbor candidate, reachability and saturation
`timescale 1ns / 1ps
module gmp_cell (
	input  logic [gmp_pkg::GAIN_W-1:0] gain,
	input  logic                       blocked,
	input  logic [gmp_pkg::COST_W-1:0] cost_l,
	input  logic [gmp_pkg::COST_W-1:0] cost_u,
	input  gmp_pkg::cell_pos_t         pos,
	input  gmp_pkg::node_t             left,
	input  gmp_pkg::node_t             up,
	output gmp_pkg::node_t             node
);
	import gmp_pkg::*;

	logic signed [TOTAL_W:0] cand_l;
	logic signed [TOTAL_W:0] cand_u;
	logic signed [TOTAL_W:0] best;
	logic                    have_l;
	logic                    have_u;
	logic                    is_start;
	logic [TOTAL_W:0]        base;
	logic [TOTAL_W:0]        sum;
	logic                    reach;

	// candidates from left and upper neighbors
	assign cand_l = signed'({1'b0, left.total}) - signed'((TOTAL_W+1)'(cost_l));
	assign cand_u = signed'({1'b0, up.total}) - signed'((TOTAL_W+1)'(cost_u));
	assign have_l = !pos.first_col && left.reach;
	assign have_u = !pos.first_row && up.reach;
	assign is_start = pos.first_row && pos.first_col;

	// pick the larger existing candidate
	always_comb begin
		if (have_l && have_u) begin
			best = (cand_u > cand_l) ? cand_u : cand_l;
		end else if (have_l) begin
			best = cand_l;
		end else begin
			best = cand_u;
		end
	end

	// reachability, add gain, saturate at the top of the total range
	assign reach = !blocked && (is_start || ((have_l || have_u) && !best[TOTAL_W]));
	assign base  = is_start ? '0 : unsigned'(best);
	assign sum   = base + (TOTAL_W+1)'(gain);

	always_comb begin
		node.reach = reach;
		if (!reach) begin
			node.total = '0;
		end else if (sum[TOTAL_W]) begin
			node.total = '1;
		end else begin
			node.total = sum[TOTAL_W-1:0];
		end
	end

endmodule

/* tb/grid_max_path_with_edge_costs_unit_tb.sv */
// testbench for the grid max-path unit: raster cell stream in, per-grid final total checked
`timescale 1ns / 1ps
module grid_max_path_with_edge_costs_unit_tb;
	import gmp_pkg::*;

	localparam int SIDE_LIMIT = MAX_SIDE_DEF;
	localparam longint TOTAL_CEIL = 64'd2147483647;

	// running best-path predictor with the queue of final totals still owed
	class grid_path_scoreboard;
		typedef struct packed {
			logic [TOTAL_W-1:0] total;
			logic               failed;
		} grid_result_t;

		logic [TOTAL_W-1:0] col_total [SIDE_LIMIT];
		logic               col_reach [SIDE_LIMIT];
		logic [TOTAL_W-1:0] left_total;
		logic               left_reach;
		int                 col;
		int                 row;
		logic [CFG_W-1:0]   size_reg;
		grid_result_t       finals_due [$];
		int                 mismatches;

		function new();
			for (int i = 0; i < SIDE_LIMIT; i++) begin
				col_total[i] = '0;
				col_reach[i] = 1'b0;
			end
			left_total = '0;
			left_reach = 1'b0;
			col = 0;
			row = 0;
			size_reg = GRID_SIZE_RESET;
			mismatches = 0;
		endfunction

		function int cur_side();
			int s;
			s = size_reg;
			if (s == 0) s = 1;
			if (s > SIDE_LIMIT) s = SIDE_LIMIT;
			return s;
		endfunction

		// a size write also restarts the raster position
		function void write_size(logic [CFG_W-1:0] v);
			size_reg = v;
			col = 0;
			row = 0;
			left_total = '0;
			left_reach = 1'b0;
		endfunction

		function int pending();
			return finals_due.size();
		endfunction

		// one accepted cell transaction
		function void note_cell(logic [15:0] gain, logic blocked, logic [15:0] cl,
				logic [15:0] cu);
			int           side;
			longint       g_l;
			longint       cl_l;
			longint       cu_l;
			longint       best;
			longint       cand;
			longint       total;
			bit           reach;
			bit           have;
			grid_result_t r;
			side = cur_side();
			g_l = gain;
			cl_l = cl;
			cu_l = cu;
			if (col >= side || row >= side) begin
				col = 0;
				row = 0;
			end
			reach = 1'b0;
			total = 0;
			if (row == 0 && col == 0) begin
				if (!blocked) begin
					reach = 1'b1;
					total = g_l;
				end
			end else if (!blocked) begin
				have = 1'b0;
				best = 0;
				if (col > 0 && left_reach) begin
					best = longint'(left_total) - cl_l;
					have = 1'b1;
				end
				if (row > 0 && col_reach[col]) begin
					cand = longint'(col_total[col]) - cu_l;
					if (!have || cand > best) best = cand;
					have = 1'b1;
				end
				if (have && best >= 0) begin
					reach = 1'b1;
					total = best + g_l;
				end
			end
			if (total > TOTAL_CEIL) total = TOTAL_CEIL;
			if (!reach) total = 0;
			col_total[col] = total[TOTAL_W-1:0];
			col_reach[col] = reach;
			left_total = total[TOTAL_W-1:0];
			left_reach = reach;
			// advance the raster position, last cell of the grid owes a result
			if (col + 1 < side) begin
				col++;
			end else begin
				col = 0;
				left_total = '0;
				left_reach = 1'b0;
				if (row + 1 < side) begin
					row++;
				end else begin
					row = 0;
					r.total = total[TOTAL_W-1:0];
					r.failed = (!reach || total <= 0);
					finals_due = {finals_due, r};
				end
			end
		endfunction

		// one accepted result transaction
		function void check_final(logic [TOTAL_W-1:0] total, logic failed);
			grid_result_t r;
			if (finals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result total=%0d failed=%0b", $realtime,
						total, failed);
				return;
			end
			r = finals_due.pop_front();
			if (r.total !== total || r.failed !== failed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch: expected total=%0d failed=%0b, got total=%0d failed=%0b",
						$realtime, r.total, r.failed, total, failed);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wen = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [47:0]        s_tdata = '0;   // cell_gain, cost_from_left, cost_from_above
	logic               s_tuser = 1'b0; // cell_blocked
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;        // final_total, zero pad
	logic               m_tuser;        // path_failed

	grid_path_scoreboard sb = new();

	int burst_left = 0;
	int random_cells = 0;
	int grid_side = MAX_SIDE_DEF;

	grid_max_path_with_edge_costs_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	// cell transactions feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_cell(s_tdata[15:0], s_tuser, s_tdata[31:16], s_tdata[47:32]);
	end

	// result transactions are checked against the oldest owed total
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_final(m_tdata[TOTAL_W-1:0], m_tuser);
	end

	// receiver back-pressure, switching at random among four patterns
	int stall_mode = 0;
	int stall_cycle = 0;
	always @(posedge clk) begin
		stall_cycle++;
		if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_cycle % 7 < 4);
		endcase
	end

	// one cell, sent inside a burst; a gap opens when the burst runs out
	task automatic send_cell(logic [15:0] gain, logic blocked, logic [15:0] cl,
			logic [15:0] cu);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cu, cl, gain};
		s_tuser <= blocked;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// stop sending and let every owed result and the pipeline clear
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_grid_size(logic [CFG_W-1:0] v);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.write_size(v);
		grid_side = sb.cur_side();
	endtask

	// friendly cells keep paths alive, noisy cells use the full field ranges
	task automatic send_random_cells(int count, bit noisy);
		logic [15:0] cl;
		for (int i = 0; i < count; i++) begin
			if (noisy) begin
				send_cell(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			end else begin
				cl = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 3000));
				send_cell(16'($urandom_range(0, 65535)), ($urandom_range(0, 19) == 0), cl,
					16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 3000)));
			end
		end
	endtask

	initial begin
		int pick;
		int style;
		bit must_write;
		logic [CFG_W-1:0] next_size;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-cell grids: max gain, blocked start, zero gain
		set_grid_size(7'd1);
		send_cell(16'hFFFF, 1'b0, 16'h0000, 16'h0000);
		send_cell(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
		send_cell(16'h0000, 1'b0, 16'h1234, 16'h4321);
		// size zero behaves as one
		set_grid_size(7'd0);
		send_cell(16'd5, 1'b0, 16'hFFFF, 16'hFFFF);

		// 2x2: zero candidate, negative candidate, unreachable left neighbor
		set_grid_size(7'd2);
		send_cell(16'd10, 1'b0, 16'd0, 16'd0);
		send_cell(16'd7, 1'b0, 16'd10, 16'd0);
		send_cell(16'd3, 1'b0, 16'd0, 16'd11);
		send_cell(16'hFFFF, 1'b0, 16'd0, 16'd0);
		// blocked start leaves the whole grid unreachable
		send_cell(16'd100, 1'b1, 16'd0, 16'd0);
		send_cell(16'd100, 1'b0, 16'd0, 16'd0);
		send_cell(16'd100, 1'b0, 16'd0, 16'd0);
		send_cell(16'd100, 1'b0, 16'd0, 16'd0);
		// maximal costs against maximal gains, blocked last cell
		send_cell(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF);
		send_cell(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF);
		send_cell(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF);
		send_cell(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);

		// a size write in the middle of a grid restarts the raster
		set_grid_size(7'd3);
		send_cell(16'd50, 1'b0, 16'd0, 16'd0);
		send_cell(16'd60, 1'b0, 16'd1, 16'd0);
		set_grid_size(7'd2);
		send_random_cells(4, 1'b0);

		// oversized setting clamps to the largest grid, three rows then abandoned
		set_grid_size(7'd127);
		send_random_cells(3 * grid_side, 1'b0);

		// many small grids, mostly well-formed, some noisy, some abandoned midway
		must_write = 1'b1;
		while (random_cells < 900) begin
			if (must_write || $urandom_range(0, 1)) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) next_size = 7'd0;
				else if (pick == 1) next_size = 7'($urandom_range(9, 16));
				else next_size = 7'($urandom_range(1, 8));
				set_grid_size(next_size);
			end
			must_write = 1'b0;
			style = $urandom_range(0, 9);
			if (style == 9) begin
				pick = $urandom_range(0, grid_side * grid_side - 1);
				send_random_cells(pick, 1'($urandom_range(0, 1)));
				random_cells += pick;
				must_write = 1'b1;
			end else begin
				send_random_cells(grid_side * grid_side, (style >= 7));
				random_cells += grid_side * grid_side;
			end
		end

		// largest legal size, two rows then stopped
		set_grid_size(7'd64);
		send_random_cells(2 * grid_side, 1'b0);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** grid_max_path_with_edge_costs_unit: PASSED **");
		else
			$display("** grid_max_path_with_edge_costs_unit: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("** grid_max_path_with_edge_costs_unit: FAILED **");
		$finish;
	end

endmodule

/* files.f */
rtl/gmp_pkg.sv
rtl/gmp_ram.sv
rtl/gmp_cell.sv
rtl/grid_max_path_with_edge_costs_unit.sv
tb/grid_max_path_with_edge_costs_unit_tb.sv
